// ----- sv/smp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package smp_pkg;
    localparam int MaxBones = 256;
    localparam int FracBits = 16;
    localparam int WordW = 32;
    localparam int CountW = 9;
    localparam int InW = 264;
    localparam int OutW = 136;
endpackage
`default_nettype wire

// ----- sv/skinning_matrix_palette_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | tdata (low bits first)             | tuser                    | tlast
// s_axis  | in  | local_cols01/23, offset_cols01/23  | parent_index, row_number | -
// m_axis  | out | final_cols01, final_cols23         | bone_index, out_row      | last
// Rows 0..2 are accepted while idle. After row 3 the parent matrix is read from the store,
// then local*parent is formed (one multiply per cycle on a shared unit, skipped for a root
// bone), then offset*global, and then the four result rows are emitted.
// The global store (8*MAX_BONES words of 64 bits) is one memory with one port.
// Reset clears only the bone index counter and control, and sets the bone count to 1.
// m_axis_tready low holds the result phase; s_axis_tready is low from row 3 until the last row is out.
module skinning_matrix_palette_top #(
    parameter int MAX_BONES = smp_pkg::MaxBones,
    parameter int FRAC_BITS = smp_pkg::FracBits
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [smp_pkg::CountW-1:0] cfg_wdata,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // local_cols01, local_cols23, offset_cols01, offset_cols23
    input  wire logic [255:0]              s_axis_tdata,
    // parent_index[8:0], row_number[10:9]
    input  wire logic [10:0]               s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // final_cols01, final_cols23
    output logic [127:0]                   m_axis_tdata,
    // bone_index[7:0], out_row[9:8]
    output logic [9:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);
    localparam int BW = $clog2(MAX_BONES);
    localparam int AW = BW + 3;
    localparam int AccW = 66 - FRAC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAR  = 3'd1;
    localparam logic [2:0] S_G    = 3'd2;
    localparam logic [2:0] S_F    = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] st_reg;
    logic [8:0] bone_count_reg;
    logic [BW-1:0] ctr_reg;
    logic [31:0] loc_reg [16];
    logic [31:0] off_reg [16];
    logic [31:0] par_reg [16];
    logic [31:0] glob_reg [16];
    logic [31:0] fin_reg [16];
    logic [7:0] praw_reg;
    logic has_par_reg;
    logic [5:0] step_reg;
    logic [1:0] orow_reg;
    logic [63:0] mem [8*MAX_BONES];
    logic [63:0] rd_reg;
    logic rd_vld_reg;
    logic [3:0] rd_idx_reg;
    logic signed [63:0] prod_reg;
    logic prod_vld_reg;
    logic [3:0] prod_dst_reg;
    logic prod_k3_reg;
    logic signed [AccW-1:0] acc_reg;

    logic [1:0] in_row;
    logic [8:0] in_par;
    assign in_row = s_axis_tuser[10:9];
    assign in_par = s_axis_tuser[8:0];
    assign s_axis_tready = (st_reg == S_IDLE);

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    logic [10:0] eff;
    always_comb
    begin
        eff = {2'b0, bone_count_reg};
        if (eff == 11'd0)
            eff = 11'd1;
        if (eff > 11'(MAX_BONES))
            eff = 11'(MAX_BONES);
    end

    // multiply operand select
    logic [1:0] mi, mj, mk;
    logic signed [31:0] opa, opb;
    assign mi = step_reg[5:4];
    assign mj = step_reg[3:2];
    assign mk = step_reg[1:0];
    always_comb
    begin
        if (st_reg == S_G)
        begin
            opa = loc_reg[{mi, mk}];
            opb = par_reg[{mk, mj}];
        end
        else
        begin
            opa = off_reg[{mi, mk}];
            opb = glob_reg[{mk, mj}];
        end
    end

    logic signed [AccW-1:0] acc_sum;
    logic signed [31:0] sat;
    assign acc_sum = acc_reg + AccW'(prod_reg >>> FRAC_BITS);
    always_comb
    begin
        if (acc_sum > AccW'(64'sd2147483647))
            sat = 32'sh7fffffff;
        else if (acc_sum < AccW'(-64'sd2147483648))
            sat = 32'sh80000000;
        else
            sat = acc_sum[31:0];
    end

    logic mem_we;
    logic [AW-1:0] mem_addr;
    logic [63:0] mem_wd;
    always_comb
    begin
        mem_we = 1'b0;
        mem_addr = {BW'(praw_reg), step_reg[2:0]};
        mem_wd = {glob_reg[{step_reg[2:1], step_reg[0], 1'b1}],
                  glob_reg[{step_reg[2:1], step_reg[0], 1'b0}]};
        if (st_reg == S_F && step_reg[5:3] == 3'd0)
        begin
            mem_we = 1'b1;
            mem_addr = {ctr_reg, step_reg[2:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        rd_reg <= mem[mem_addr];
    end

    logic last_mul;
    assign last_mul = (step_reg == 6'd63);

    logic drain_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            bone_count_reg <= 9'd1;
            ctr_reg <= '0;
            step_reg <= '0;
            orow_reg <= '0;
            rd_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
            drain_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                bone_count_reg <= cfg_wdata;
            rd_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    drain_reg <= 1'b0;
                    if (accept && in_row == 2'd3)
                        st_reg <= S_PAR;
                end
                S_PAR:
                begin
                    if (step_reg < 6'd8)
                    begin
                        rd_vld_reg <= 1'b1;
                        step_reg <= step_reg + 6'd1;
                    end
                    else if (!rd_vld_reg)
                    begin
                        step_reg <= '0;
                        st_reg <= has_par_reg ? S_G : S_F;
                    end
                end
                S_G, S_F:
                begin
                    if (!drain_reg)
                    begin
                        prod_vld_reg <= 1'b1;
                        step_reg <= step_reg + 6'd1;
                        if (last_mul)
                            drain_reg <= 1'b1;
                    end
                    else if (!prod_vld_reg)
                    begin
                        drain_reg <= 1'b0;
                        step_reg <= '0;
                        if (st_reg == S_G)
                            st_reg <= S_F;
                        else
                        begin
                            st_reg <= S_OUT;
                            orow_reg <= '0;
                        end
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        orow_reg <= orow_reg + 2'd1;
                        if (orow_reg == 2'd3)
                        begin
                            st_reg <= S_IDLE;
                            if (11'(ctr_reg) + 11'd1 >= eff)
                                ctr_reg <= '0;
                            else
                                ctr_reg <= ctr_reg + 1'b1;
                        end
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= {step_reg[2:0], 1'b0};
        if (accept)
        begin
            loc_reg[{in_row, 2'd0}] <= s_axis_tdata[31:0];
            loc_reg[{in_row, 2'd1}] <= s_axis_tdata[63:32];
            loc_reg[{in_row, 2'd2}] <= s_axis_tdata[95:64];
            loc_reg[{in_row, 2'd3}] <= s_axis_tdata[127:96];
            off_reg[{in_row, 2'd0}] <= s_axis_tdata[159:128];
            off_reg[{in_row, 2'd1}] <= s_axis_tdata[191:160];
            off_reg[{in_row, 2'd2}] <= s_axis_tdata[223:192];
            off_reg[{in_row, 2'd3}] <= s_axis_tdata[255:224];
            praw_reg <= in_par[7:0];
            has_par_reg <= !in_par[8] && (in_par < 9'(ctr_reg));
        end
        if (st_reg == S_PAR && step_reg == 6'd8 && !rd_vld_reg && !has_par_reg)
            for (int i = 0; i < 16; i++)
                glob_reg[i] <= loc_reg[i];
        if (rd_vld_reg)
        begin
            par_reg[rd_idx_reg] <= rd_reg[31:0];
            par_reg[rd_idx_reg + 4'd1] <= rd_reg[63:32];
        end
        if ((st_reg == S_G || st_reg == S_F) && !drain_reg)
        begin
            prod_reg <= opa * opb;
            prod_dst_reg <= {mi, mj};
            prod_k3_reg <= (mk == 2'd3);
        end
        if (prod_vld_reg)
        begin
            if (prod_k3_reg)
            begin
                acc_reg <= '0;
                if (st_reg == S_G)
                    glob_reg[prod_dst_reg] <= sat;
                else
                    fin_reg[prod_dst_reg] <= sat;
            end
            else
                acc_reg <= acc_sum;
        end
        else if (st_reg != S_G && st_reg != S_F)
            acc_reg <= '0;
    end

    assign m_axis_tvalid = (st_reg == S_OUT);
    assign m_axis_tdata = {fin_reg[{orow_reg, 2'd3}], fin_reg[{orow_reg, 2'd2}],
                           fin_reg[{orow_reg, 2'd1}], fin_reg[{orow_reg, 2'd0}]};
    assign m_axis_tuser = {orow_reg, 8'(ctr_reg)};
    assign m_axis_tlast = (orow_reg == 2'd3);

    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while emitting");
    a_ctr: assert property (@(posedge clk) disable iff (!rst_n)
        11'(ctr_reg) < 11'(MAX_BONES)) else $error("counter range");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("no return to idle");
endmodule
`default_nettype wire
